@@ hw/rtl/ttls_pkg.sv @@
`timescale 1ns / 1ps

package ttls_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int TIME_W       = 16;
    localparam int DRIVE_W      = 14;
    localparam int OUT_DRIVE_W  = 15;
    localparam int STEP_W       = 4;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 40;

    localparam logic [TIME_W-1:0]  FWD_TIME_RST   = 16'd250;
    localparam logic [DRIVE_W-1:0] FWD_DRIVE_RST  = 14'd500;
    localparam logic [DRIVE_W-1:0] TURN_DRIVE_RST = 14'd3000;
    localparam logic [TIME_W-1:0]  STEP_TIME_RST  = 16'd350;
    localparam logic [TIME_W-1:0]  PAUSE_TIME_RST = 16'd50;
    localparam logic [STEP_W-1:0]  STEP_LIMIT_RST = 4'd4;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FWD_TIME   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FWD_DRIVE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TURN_DRIVE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_TIME  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAUSE_TIME = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_LIMIT = 3'd5;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FWD   = 2'd1,
        PH_PIVOT = 2'd2,
        PH_PAUSE = 2'd3
    } t_phase;

    typedef struct packed {
        logic                          line_found;
        logic                          finished;
        t_phase                        phase;
        logic signed [OUT_DRIVE_W-1:0] right_drive;
        logic signed [OUT_DRIVE_W-1:0] left_drive;
    } t_result;

    // two adjacent marks at either end of the sensor bar
    function automatic logic edge_pair(input logic [SENSOR_COUNT-1:0] m);
        return (m[0] & m[1]) | (m[1] & m[2]) | (m[5] & m[6]) | (m[6] & m[7]);
    endfunction

endpackage

@@ hw/rtl/ttls_core.sv @@
`timescale 1ns / 1ps

module ttls_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ttls_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [ttls_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_accept,
    input  logic                                i_kind,
    input  logic [ttls_pkg::SENSOR_COUNT-1:0]   i_sensor_bits,
    output ttls_pkg::t_result                   o_result
);
    import ttls_pkg::*;

    logic [TIME_W-1:0]       r_fwd_time;
    logic [DRIVE_W-1:0]      r_fwd_drive;
    logic [DRIVE_W-1:0]      r_turn_drive;
    logic [TIME_W-1:0]       r_step_time;
    logic [TIME_W-1:0]       r_pause_time;
    logic [STEP_W-1:0]       r_step_limit;

    t_phase                  r_phase, n_phase;
    logic [TIME_W-1:0]       r_elapsed, n_elapsed;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [SENSOR_COUNT-1:0] r_marks, n_marks;

    logic [TIME_W-1:0]       elapsed_inc;
    logic [STEP_W-1:0]       step_inc;
    logic [SENSOR_COUNT-1:0] marks_or;
    logic [TIME_W-1:0]       time_limit;
    logic                    time_done;
    logic                    fin, found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_time   <= FWD_TIME_RST;
            r_fwd_drive  <= FWD_DRIVE_RST;
            r_turn_drive <= TURN_DRIVE_RST;
            r_step_time  <= STEP_TIME_RST;
            r_pause_time <= PAUSE_TIME_RST;
            r_step_limit <= STEP_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FWD_TIME:   r_fwd_time   <= i_cfg_wdata;
                CFG_FWD_DRIVE:  r_fwd_drive  <= i_cfg_wdata[DRIVE_W-1:0];
                CFG_TURN_DRIVE: r_turn_drive <= i_cfg_wdata[DRIVE_W-1:0];
                CFG_STEP_TIME:  r_step_time  <= i_cfg_wdata;
                CFG_PAUSE_TIME: r_pause_time <= i_cfg_wdata;
                CFG_STEP_LIMIT: r_step_limit <= i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_step    <= '0;
            r_marks   <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_step    <= n_step;
            r_marks   <= n_marks;
        end
    end

    assign elapsed_inc = r_elapsed + 1'b1;
    assign step_inc    = r_step + 1'b1;
    assign marks_or    = r_marks | ~i_sensor_bits;

    always_comb begin
        case (r_phase)
            PH_FWD:   time_limit = r_fwd_time;
            PH_PIVOT: time_limit = r_step_time;
            default:  time_limit = r_pause_time;
        endcase
    end

    // a wrapped counter also ends the phase, so a zero time acts like one tick
    assign time_done = (elapsed_inc >= time_limit) || (elapsed_inc == '0);

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_step    = r_step;
        n_marks   = r_marks;
        fin       = 1'b0;
        found     = 1'b0;
        if (i_kind == KIND_START) begin
            if (r_phase == PH_IDLE) begin
                n_phase   = PH_FWD;
                n_elapsed = '0;
                n_step    = '0;
                n_marks   = '0;
            end
        end else begin
            case (r_phase)
                PH_FWD: begin
                    n_elapsed = elapsed_inc;
                    if (time_done) begin
                        n_elapsed = '0;
                        n_step    = '0;
                        if (r_step_limit == '0) begin
                            n_phase = PH_IDLE;
                            fin     = 1'b1;
                        end else begin
                            n_phase = PH_PIVOT;
                        end
                    end
                end
                PH_PIVOT: begin
                    n_marks = marks_or;
                    if (edge_pair(marks_or)) begin
                        n_phase = PH_IDLE;
                        fin     = 1'b1;
                        found   = 1'b1;
                    end else begin
                        n_elapsed = elapsed_inc;
                        if (time_done) begin
                            n_phase   = PH_PAUSE;
                            n_elapsed = '0;
                        end
                    end
                end
                PH_PAUSE: begin
                    n_marks   = marks_or;
                    n_elapsed = elapsed_inc;
                    if (time_done) begin
                        n_elapsed = '0;
                        if (edge_pair(marks_or)) begin
                            n_phase = PH_IDLE;
                            fin     = 1'b1;
                            found   = 1'b1;
                        end else begin
                            n_marks = '0;
                            n_step  = step_inc;
                            if ((step_inc >= r_step_limit) || (step_inc == '0)) begin
                                n_phase = PH_IDLE;
                                fin     = 1'b1;
                            end else begin
                                n_phase = PH_PIVOT;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_result.line_found  = found;
        o_result.finished    = fin;
        o_result.phase       = n_phase;
        o_result.left_drive  = '0;
        o_result.right_drive = '0;
        case (n_phase)
            PH_FWD: begin
                o_result.left_drive  = signed'({1'b0, r_fwd_drive});
                o_result.right_drive = signed'({1'b0, r_fwd_drive});
            end
            PH_PIVOT: begin
                o_result.left_drive  = -signed'({1'b0, r_turn_drive});
                o_result.right_drive = signed'({1'b0, r_turn_drive});
            end
            default: ;
        endcase
    end

    a_fin_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.finished) |=> (r_phase == PH_IDLE))
        else $error("sequence end did not return to idle");

    a_found_is_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.line_found |-> o_result.finished)
        else $error("line found without finish");

    a_busy_start_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_kind == KIND_START) && (r_phase != PH_IDLE))
        |=> ($stable(r_phase) && $stable(r_elapsed) && $stable(r_marks)))
        else $error("start while busy changed state");

    a_idle_tick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_kind == KIND_TICK) && (r_phase == PH_IDLE)) |-> (o_result == '0))
        else $error("tick while idle gave nonzero result");

endmodule

@@ hw/rtl/ttls_skid.sv @@
`timescale 1ns / 1ps

module ttls_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ttls_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_pop_ready,
    output ttls_pkg::t_result o_data
);
    import ttls_pkg::*;

    logic    r_valid0, r_valid1;
    t_result r_data0, r_data1;
    logic    pop;

    assign pop     = r_valid0 & i_pop_ready;
    assign o_ready = !r_valid1;
    assign o_valid = r_valid0;
    assign o_data  = r_data0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
            r_valid1 <= 1'b0;
        end else if (pop) begin
            if (r_valid1) begin
                r_valid0 <= 1'b1;
                r_valid1 <= i_push;
            end else begin
                r_valid0 <= i_push;
            end
        end else if (i_push) begin
            if (!r_valid0) begin
                r_valid0 <= 1'b1;
            end else begin
                r_valid1 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_valid1) begin
                r_data0 <= r_data1;
                r_data1 <= i_data;
            end else begin
                r_data0 <= i_data;
            end
        end else if (i_push) begin
            if (!r_valid0) begin
                r_data0 <= i_data;
            end else begin
                r_data1 <= i_data;
            end
        end
    end

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid1 |-> r_valid0)
        else $error("skid entry held with empty output stage");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid1 && !pop) |=> (r_valid1 && $stable(r_data0)))
        else $error("skid contents lost under stall");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid0 && r_valid1 && !i_pop_ready) |-> !(i_push && o_ready))
        else $error("transfer taken with full buffer");

endmodule

@@ hw/rtl/timed_turn_line_seek_sequencer_top.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Signals                              Contents
// input     in   s_axis_tvalid/tready/tdata/tuser     start or 1 ms tick, sensor bits
// result    out  m_axis_tvalid/tready/tdata           wheel drives, phase, end flags
// config    in   i_cfg_we/i_cfg_addr/i_cfg_wdata      six timing and drive registers
//
// One result per input transfer; a transfer can be taken every cycle while
// s_axis_tready is high. The result is registered into a result slot.
// Two result slots (output register plus skid) let one more transfer in
// during an output stall; s_axis_tready drops only when both slots are full.
// i_rst_n is synchronous: idle phase, counters and marks cleared, registers
// back to their defaults.

module timed_turn_line_seek_sequencer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ttls_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [ttls_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ttls_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] sensor_bits
    input  logic                               s_axis_tuser,  // [0] kind
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [14:0] left_drive, [29:15] right_drive, [31:30] phase, [32] finished,
    // [33] line_found, [39:34] zero
    output logic [ttls_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import ttls_pkg::*;

    localparam int RES_W = $bits(t_result);

    logic    accept;
    t_result core_res;
    t_result out_res;

    assign accept = s_axis_tvalid & s_axis_tready;

    ttls_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (accept),
        .i_kind        (s_axis_tuser),
        .i_sensor_bits (s_axis_tdata[SENSOR_COUNT-1:0]),
        .o_result      (core_res)
    );

    ttls_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (core_res),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_data      (out_res)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-RES_W){1'b0}}, out_res};

endmodule

@@ tb/timed_turn_line_seek_sequencer_top_test.sv @@
`timescale 1ns / 1ps

module timed_turn_line_seek_sequencer_top_test;
    import ttls_pkg::*;

    typedef struct packed {
        logic                    kind;
        logic [SENSOR_COUNT-1:0] sensors;
    } t_item;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    timed_turn_line_seek_sequencer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // shadow registers
    logic [TIME_W-1:0]  cfg_fwd_time   = FWD_TIME_RST;
    logic [DRIVE_W-1:0] cfg_fwd_drive  = FWD_DRIVE_RST;
    logic [DRIVE_W-1:0] cfg_turn_drive = TURN_DRIVE_RST;
    logic [TIME_W-1:0]  cfg_step_time  = STEP_TIME_RST;
    logic [TIME_W-1:0]  cfg_pause_time = PAUSE_TIME_RST;
    logic [STEP_W-1:0]  cfg_step_limit = STEP_LIMIT_RST;

    // predicted sequencer state
    t_phase                  seq_phase = PH_IDLE;
    logic [TIME_W-1:0]       seq_ticks = '0;
    logic [STEP_W-1:0]       seq_steps = '0;
    logic [SENSOR_COUNT-1:0] seq_marks = '0;

    t_item   tick_queue[$];
    t_result predicted_outputs[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_rx = 1'b0;

    int errors        = 0;
    int inputs_taken  = 0;
    int results_seen  = 0;
    int finds         = 0;
    int give_ups      = 0;
    int settings_used = 1;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("MISMATCH at %0t ns, result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    function automatic logic has_edge_pair(input logic [SENSOR_COUNT-1:0] m);
        return (m[1:0] == 2'b11) || (m[2:1] == 2'b11) ||
               (m[6:5] == 2'b11) || (m[7:6] == 2'b11);
    endfunction

    // a zero limit still takes one tick; counter wrap also ends the phase
    function automatic logic timer_expired(input logic [TIME_W-1:0] limit);
        seq_ticks = seq_ticks + 1'b1;
        return (seq_ticks >= limit) || (seq_ticks == '0);
    endfunction

    function automatic t_result advance_sequencer(input logic kind,
                                                  input logic [SENSOR_COUNT-1:0] bits);
        t_result r;
        r = '0;
        if (kind == KIND_START) begin
            if (seq_phase == PH_IDLE) begin
                seq_phase = PH_FWD;
                seq_ticks = '0;
                seq_steps = '0;
                seq_marks = '0;
            end
        end else begin
            case (seq_phase)
                PH_FWD: begin
                    if (timer_expired(cfg_fwd_time)) begin
                        seq_ticks = '0;
                        seq_steps = '0;
                        if (cfg_step_limit == '0) begin
                            seq_phase  = PH_IDLE;
                            r.finished = 1'b1;
                        end else begin
                            seq_phase = PH_PIVOT;
                        end
                    end
                end
                PH_PIVOT: begin
                    seq_marks = seq_marks | ~bits;
                    if (has_edge_pair(seq_marks)) begin
                        seq_phase    = PH_IDLE;
                        r.finished   = 1'b1;
                        r.line_found = 1'b1;
                    end else if (timer_expired(cfg_step_time)) begin
                        seq_phase = PH_PAUSE;
                        seq_ticks = '0;
                    end
                end
                PH_PAUSE: begin
                    seq_marks = seq_marks | ~bits;
                    // pause only looks at the marks on its last tick
                    if (timer_expired(cfg_pause_time)) begin
                        seq_ticks = '0;
                        if (has_edge_pair(seq_marks)) begin
                            seq_phase    = PH_IDLE;
                            r.finished   = 1'b1;
                            r.line_found = 1'b1;
                        end else begin
                            seq_marks = '0;
                            seq_steps = seq_steps + 1'b1;
                            if (seq_steps >= cfg_step_limit || seq_steps == '0) begin
                                seq_phase  = PH_IDLE;
                                r.finished = 1'b1;
                            end else begin
                                seq_phase = PH_PIVOT;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (seq_phase == PH_FWD) begin
            r.left_drive  = {1'b0, cfg_fwd_drive};
            r.right_drive = {1'b0, cfg_fwd_drive};
        end else if (seq_phase == PH_PIVOT) begin
            r.left_drive  = -$signed({1'b0, cfg_turn_drive});
            r.right_drive = {1'b0, cfg_turn_drive};
        end
        r.phase = seq_phase;
        return r;
    endfunction

    // sender
    always @(posedge i_clk) begin : item_driver
        t_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = tick_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= it.kind;
                s_axis_tdata  <= it.sensors;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : input_monitor
        t_result r;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            r = advance_sequencer(s_axis_tuser, s_axis_tdata);
            predicted_outputs.push_back(r);
            inputs_taken++;
            if (r.finished) begin
                if (r.line_found)
                    finds++;
                else
                    give_ups++;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            if (predicted_outputs.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = predicted_outputs.pop_front();
                if ($isunknown(m_axis_tdata))
                    report_mismatch("unknown bits in result");
                check_field("left_drive", got.left_drive, want.left_drive);
                check_field("right_drive", got.right_drive, want.right_drive);
                check_field("phase", got.phase, want.phase);
                check_field("finished", got.finished, want.finished);
                check_field("line_found", got.line_found, want.line_found);
                check_field("padding", m_axis_tdata[OUT_DATA_W-1:$bits(t_result)], 0);
            end
        end
    end

    task automatic push_item(input logic kind, input logic [SENSOR_COUNT-1:0] bits);
        t_item it;
        it.kind    = kind;
        it.sensors = bits;
        tick_queue.push_back(it);
    endtask

    // one start and ticks to run the sequence out, capped at the forward time
    // plus 160; line_pct is the chance per tick of a fully random sensor
    // byte, otherwise only marks that never pair up (sensors 1 and 6 stay dark)
    task automatic push_run(input int line_pct);
        int span;
        int cap;
        int n;
        span = (cfg_fwd_time == '0) ? 1 : int'(cfg_fwd_time);
        cap  = span + 160;
        if (cfg_step_limit != '0)
            span += int'(cfg_step_limit) *
                    (((cfg_step_time == '0) ? 1 : int'(cfg_step_time)) +
                     ((cfg_pause_time == '0) ? 1 : int'(cfg_pause_time)));
        if (span > cap)
            span = cap;
        push_item(KIND_START, 8'($urandom));
        for (n = 0; n < span + $urandom_range(0, 2); n++) begin
            if ($urandom_range(99) < 2)
                push_item(KIND_START, 8'($urandom));
            if ($urandom_range(99) < line_pct)
                push_item(KIND_TICK, 8'($urandom));
            else
                push_item(KIND_TICK, ~(8'($urandom) & 8'hBD));
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        case (idx)
            CFG_FWD_TIME:   cfg_fwd_time   = v;
            CFG_FWD_DRIVE:  cfg_fwd_drive  = v[DRIVE_W-1:0];
            CFG_TURN_DRIVE: cfg_turn_drive = v[DRIVE_W-1:0];
            CFG_STEP_TIME:  cfg_step_time  = v;
            CFG_PAUSE_TIME: cfg_pause_time = v;
            CFG_STEP_LIMIT: cfg_step_limit = v[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_registers(input int fwd_t, input int fwd_d, input int turn_d,
                                 input int step_t, input int pause_t, input int limit);
        write_reg(CFG_FWD_TIME, CFG_DATA_W'(fwd_t));
        write_reg(CFG_FWD_DRIVE, CFG_DATA_W'(fwd_d));
        write_reg(CFG_TURN_DRIVE, CFG_DATA_W'(turn_d));
        write_reg(CFG_STEP_TIME, CFG_DATA_W'(step_t));
        write_reg(CFG_PAUSE_TIME, CFG_DATA_W'(pause_t));
        write_reg(CFG_STEP_LIMIT, CFG_DATA_W'(limit));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_used++;
    endtask

    task automatic wait_drained;
        @(negedge i_clk);
        while (tick_queue.size() != 0 || s_axis_tvalid || predicted_outputs.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_random(input int budget, input int line_pct);
        int start_len;
        start_len = tick_queue.size();
        while (tick_queue.size() - start_len < budget) begin
            if (line_pct >= 0)
                push_run(line_pct);
            else
                case ($urandom_range(3))
                    0: push_run(0);
                    1: push_run(2);
                    2: push_run(10);
                    default: push_run(40);
                endcase
        end
        wait_drained();
    endtask

    initial begin : stimulus
        int k;
        send_idle_pct = 7;
        recv_idle_pct = 56;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values of every register
        push_run(10);
        wait_drained();

        // directed walk through forward, pivot, pause and both kinds of find
        set_registers(2, 1234, 4321, 3, 3, 2);
        push_item(KIND_TICK, 8'h00);   // tick while idle
        push_item(KIND_START, 8'hA5);
        push_item(KIND_START, 8'h5A);  // start while busy
        push_item(KIND_TICK, 8'h00);   // forward phase keeps no marks
        push_item(KIND_TICK, 8'h00);
        push_item(KIND_TICK, 8'hFE);
        push_item(KIND_TICK, 8'hFB);   // sensors 0 and 2 are not a pair
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_TICK, 8'hFF);   // failed pause clears marks
        push_item(KIND_TICK, 8'h7F);
        push_item(KIND_TICK, 8'hBF);   // 6-7 pair while pivoting
        push_item(KIND_START, 8'hFF);
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_TICK, 8'hFC);   // pair seen early in pause, taken at its end
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_TICK, 8'hFF);
        wait_drained();

        set_registers(0, 0, 10000, 0, 0, 1);
        run_random(50, -1);
        set_registers(3, 10000, 0, 5, 4, 15);
        run_random(50, -1);

        send_idle_pct = 56;
        recv_idle_pct = 7;
        set_registers(1, 777, 9999, 2, 1, 0);
        run_random(50, -1);
        set_registers(4, 2500, 6000, 8, 3, 3);
        run_random(50, -1);
        set_registers($urandom_range(0, 6), $urandom_range(0, 10000), $urandom_range(0, 10000),
                      $urandom_range(1, 8), $urandom_range(0, 5), $urandom_range(0, 15));
        run_random(50, -1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < 2; k++) begin
            set_registers($urandom_range(0, 6), $urandom_range(0, 10000),
                          $urandom_range(0, 10000), $urandom_range(0, 8),
                          $urandom_range(0, 5), $urandom_range(0, 15));
            run_random(50, -1);
        end
        // widest drives and step times behind a short straight phase
        set_registers(5, 10000, 10000, 65535, 65535, 15);
        run_random(1, 40);

        if (predicted_outputs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_outputs.size()));
        $display("Covered %0d input transfers and %0d result transfers over %0d settings.",
                 inputs_taken, results_seen, settings_used);
        $display("Sequences ended with the line found %0d times and gave up %0d times.",
                 finds, give_ups);
        if (errors == 0)
            $display("timed_turn_line_seek_sequencer_top_test OK");
        else
            $display("timed_turn_line_seek_sequencer_top_test NOT OK");
        $finish;
    end

    // long output stall while input keeps coming, to back up the skid slots
    initial begin : rx_hold_off
        int n;
        wait (inputs_taken >= 120);
        @(negedge i_clk);
        hold_rx = 1'b1;
        for (n = 0; n < 300; n++)
            @(negedge i_clk);
        hold_rx = 1'b0;
    end

    initial begin : watchdog
        #20_000_000;
        $display("timed_turn_line_seek_sequencer_top_test NOT OK");
        $finish;
    end

endmodule
